// ===== rtl/core/pua_pkg.sv =====
`default_nettype none
package pua_pkg;

  // Flag word layout.
  localparam int FlagW = 6;
  localparam logic [FlagW-1:0] FLAG_CACHES   = 6'h01;
  localparam logic [FlagW-1:0] FLAG_IRAM8K   = 6'h02;
  localparam logic [FlagW-1:0] FLAG_DRAM8K   = 6'h04;
  localparam logic [FlagW-1:0] FLAG_MINIBIOS = 6'h08;
  localparam logic [FlagW-1:0] FLAG_BIOS_OWN = 6'h10;
  localparam logic [FlagW-1:0] FLAG_USER_OWN = 6'h20;
  localparam logic [FlagW-1:0] OWN_ANY       = 6'h30;

  // Function codes.
  localparam logic [2:0] FN_RESET  = 3'd0;
  localparam logic [2:0] FN_ALLOC  = 3'd1;
  localparam logic [2:0] FN_SPEC   = 3'd2;
  localparam logic [2:0] FN_FREE   = 3'd3;
  localparam logic [2:0] FN_STATUS = 3'd4;
  localparam logic [2:0] FN_COUNT  = 3'd5;

  localparam logic [31:0] NO_UNIT     = 32'hFFFF_FFFF;
  localparam logic [31:0] TOTAL_UNITS = 32'd4;

  // Result of checking one unit against the current request.
  typedef struct packed {
    logic fit;    // unit may be handed out for the requested capabilities
    logic exact;  // unit's base capabilities match the request exactly
    logic idle;   // allocatable unit with no ownership bit
  } eval_t;

  // Capability flags that a unit has after reset.
  function automatic logic [FlagW-1:0] base_flags(input logic [1:0] idx);
    logic [FlagW-1:0] f;
    case (idx)
      2'd0: f = FLAG_CACHES | FLAG_IRAM8K | FLAG_DRAM8K;
      2'd3: f = FLAG_CACHES;
      default: f = '0;
    endcase
    return f;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/processor_unit_allocator.sv =====
// One request at a time: the shared compare unit visits units 0..3, one per cycle,
// a commit writes the flag update and the answer, and the input reopens in the cycle
// after the commit.
// The answer register frees the input side; a stalled answer holds off the next commit.
// Reset (rst, synchronous): flags return to 7, 0, 0, 1 with no ownership, mask to 0.
`default_nettype none
module processor_unit_allocator
  import pua_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wen,
  input  wire logic [2:0]  cfg_wdata,   // minibios_mask
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,     // [2:0] func, [34:3] argument, [39:35] zero
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata      // [31:0] answer
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]       state;
  logic [1:0]       idx;
  logic [2:0]       minibios_mask;
  logic [FlagW-1:0] flags [4];
  logic [2:0]       func_q;
  logic [31:0]      arg_q;
  logic [1:0]       pick;
  logic             have_pick;
  logic             have_exact;
  logic [1:0]       nfree;
  logic [FlagW-1:0] sel_flags;

  eval_t            ev;
  logic             s_fire;
  logic             fin_fire;
  logic             arg_lt3;
  logic             arg_lt4;
  logic [31:0]      answer_next;
  logic [3:0]       mb4;

  assign s_tready = (state == ST_IDLE);
  assign s_fire   = s_tvalid && s_tready;
  assign fin_fire = (state == ST_FIN) && (!m_tvalid || m_tready);
  assign arg_lt4  = (arg_q[31:2] == 30'd0);
  assign arg_lt3  = arg_lt4 && (arg_q[1:0] != 2'd3);
  assign mb4      = {1'b0, minibios_mask};

  pua_eval u_eval (
    .flags (flags[idx]),
    .idx   (idx),
    .want  (arg_q[3:0]),
    .res   (ev)
  );

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      minibios_mask <= '0;
    end else if (cfg_wen) begin
      minibios_mask <= cfg_wdata;
    end
  end

  // Sequencer: accept, scan four units, then commit.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_fire) begin
            state <= ST_SCAN;
            idx   <= '0;
          end
        end
        ST_SCAN: begin
          idx <= idx + 2'd1;
          if (idx == 2'd3) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (fin_fire) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Request capture and scan accumulators.
  always_ff @(posedge clk) begin
    if (s_fire) begin
      func_q     <= s_tdata[2:0];
      arg_q      <= s_tdata[34:3];
      have_pick  <= 1'b0;
      have_exact <= 1'b0;
      nfree      <= '0;
      pick       <= '0;
    end else if (state == ST_SCAN) begin
      if (ev.idle) begin
        nfree <= nfree + 2'd1;
      end
      // First exact match wins; otherwise the first unit that fits.
      if (ev.fit && !have_exact) begin
        if (ev.exact) begin
          pick       <= idx;
          have_pick  <= 1'b1;
          have_exact <= 1'b1;
        end else if (!have_pick) begin
          pick      <= idx;
          have_pick <= 1'b1;
        end
      end
      if (idx == arg_q[1:0]) begin
        sel_flags <= flags[idx];
      end
    end
  end

  // Answer for the request being committed.
  always_comb begin
    case (func_q)
      FN_RESET:  answer_next = '0;
      FN_ALLOC:  answer_next = have_pick ? {30'd0, pick} : NO_UNIT;
      FN_SPEC:   answer_next = (arg_lt3 && ((sel_flags & OWN_ANY) == '0)) ? arg_q : NO_UNIT;
      FN_FREE: begin
        if (!arg_lt3) begin
          answer_next = NO_UNIT;
        end else if (sel_flags[5]) begin
          answer_next = '0;
        end else begin
          answer_next = arg_q;
        end
      end
      FN_STATUS: answer_next = arg_lt4 ? {26'd0, sel_flags} : '0;
      FN_COUNT:  answer_next = (arg_q == 32'd1) ? TOTAL_UNITS : {30'd0, nfree};
      default:   answer_next = '0;
    endcase
  end

  // Flag store updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        flags[i] <= base_flags(2'(i));
      end
    end else if (fin_fire) begin
      case (func_q)
        FN_RESET: begin
          for (int i = 0; i < 4; i++) begin
            flags[i] <= base_flags(2'(i))
                      | (mb4[i] ? FLAG_MINIBIOS : '0)
                      | ((arg_q == 32'(i)) ? OWN_ANY : '0);
          end
        end
        FN_ALLOC: begin
          if (have_pick) begin
            flags[pick] <= flags[pick] | FLAG_USER_OWN;
          end
        end
        FN_SPEC: begin
          if (arg_lt3 && ((sel_flags & OWN_ANY) == '0)) begin
            flags[arg_q[1:0]] <= sel_flags | FLAG_USER_OWN;
          end
        end
        FN_FREE: begin
          if (arg_lt3 && sel_flags[5]) begin
            flags[arg_q[1:0]] <= sel_flags & ~FLAG_USER_OWN;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Answer register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fin_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_fire) begin
      m_tdata <= answer_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/pua_eval.sv =====
`default_nettype none
module pua_eval
  import pua_pkg::*;
(
  input  wire logic [FlagW-1:0] flags,
  input  wire logic [1:0]       idx,
  input  wire logic [3:0]       want,
  output eval_t                 res
);

  logic             allocatable;
  logic [3:0]       caps;
  logic             mb_block;
  logic [FlagW-1:0] base_all;
  logic [3:0]       base_caps;

  // Shared compare unit, applied to one unit per scan step.
  always_comb begin
    allocatable = (idx != 2'd3);
    caps        = flags[3:0];
    base_all    = base_flags(idx);
    base_caps   = base_all[3:0];
    // A mini-BIOS unit serves only a pure mini-BIOS request.
    mb_block    = caps[3] && (!want[3] || (want[2:0] != 3'b000));
    res.fit     = allocatable && !flags[5] && ((caps & want) == want) && !mb_block;
    res.exact   = (base_caps == {1'b0, want[2:0]});
    res.idle    = allocatable && ((flags & OWN_ANY) == '0);
  end

endmodule
`default_nettype wire

// ===== rtl/core/pua_checker.sv =====
`default_nettype none
module pua_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata
);

  // A stalled answer holds its value.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("answer changed while stalled");

  // The block is busy right after taking a request.
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while busy");

  // The block stays busy while the scan reaches the last unit.
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> ##3 !s_tready)
    else $error("scan finished too early");

  // Reset leaves no answer pending and the input side open.
  assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("bad state after reset");

endmodule

bind processor_unit_allocator pua_checker u_pua_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire

// ===== verif/processor_unit_allocator_check.sv =====
`timescale 1ns / 1ps
module processor_unit_allocator_check
  import pua_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wen,
  input  wire logic [2:0]  cfg_wdata,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [39:0] s_tdata,     // [2:0] func, [34:3] argument, [39:35] zero
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [31:0] m_tdata,     // [31:0] answer
  output int               fail_count,
  output int               pending
);

  // Shadow copy of the unit flags and the mini-BIOS mask.
  logic [FlagW-1:0] unit_state [4];
  logic [2:0]       bios_mask;
  logic [31:0]      answers_due [$];
  int               errors = 0;
  int               due_count = 0;

  assign fail_count = errors;
  assign pending    = due_count;

  // Capability flags each unit starts from after a reset.
  function automatic logic [FlagW-1:0] home_caps(input int u);
    logic [FlagW-1:0] caps;
    case (u)
      0: caps = FLAG_CACHES | FLAG_IRAM8K | FLAG_DRAM8K;
      3: caps = FLAG_CACHES;
      default: caps = '0;
    endcase
    return caps;
  endfunction

  // Apply one request to the shadow state and return the answer it must give.
  function automatic logic [31:0] serve_request(input logic [2:0] fn, input logic [31:0] arg);
    logic [31:0]      answer;
    logic [3:0]       want;
    logic [3:0]       caps;
    logic [FlagW-1:0] base;
    logic [1:0]       u;
    logic             exact_found;
    int               free_units;
    u = arg[1:0];
    answer = '0;
    case (fn)
      FN_RESET: begin
        for (int i = 0; i < 4; i++) unit_state[i] = home_caps(i);
        for (int i = 0; i < 3; i++) begin
          if (bios_mask[i]) unit_state[i] = unit_state[i] | FLAG_MINIBIOS;
        end
        if (arg < 4) unit_state[u] = unit_state[u] | OWN_ANY;
      end
      FN_ALLOC: begin
        // An exact match on the home capabilities wins; otherwise the first fit.
        want = arg[3:0];
        answer = NO_UNIT;
        exact_found = 1'b0;
        for (int i = 0; i < 3; i++) begin
          caps = unit_state[i][3:0];
          base = home_caps(i);
          if (!exact_found && !unit_state[i][5] && ((caps & want) == want) &&
              !(caps[3] && (!want[3] || (want[2:0] != 3'b000)))) begin
            if (base == {3'b000, want[2:0]}) begin
              answer = i;
              exact_found = 1'b1;
            end else if (answer == NO_UNIT) begin
              answer = i;
            end
          end
        end
        if (answer != NO_UNIT)
          unit_state[answer[1:0]] = unit_state[answer[1:0]] | FLAG_USER_OWN;
      end
      FN_SPEC: begin
        if (arg >= 3 || (unit_state[u] & OWN_ANY) != '0) begin
          answer = NO_UNIT;
        end else begin
          unit_state[u] = unit_state[u] | FLAG_USER_OWN;
          answer = arg;
        end
      end
      FN_FREE: begin
        if (arg >= 3) begin
          answer = NO_UNIT;
        end else if (unit_state[u][5]) begin
          unit_state[u] = unit_state[u] & ~FLAG_USER_OWN;
          answer = '0;
        end else begin
          answer = arg;
        end
      end
      FN_STATUS: begin
        if (arg < 4) answer = {26'd0, unit_state[u]};
      end
      FN_COUNT: begin
        free_units = 0;
        for (int i = 0; i < 3; i++) begin
          if ((unit_state[i] & OWN_ANY) == '0) free_units++;
        end
        answer = (arg == 1) ? TOTAL_UNITS : free_units;
      end
      default: answer = '0;
    endcase
    return answer;
  endfunction

  // Follow both channels and the register port on every rising edge.
  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) unit_state[i] = home_caps(i);
      bios_mask = '0;
      answers_due.delete();
    end else begin
      if (cfg_wen) bios_mask = cfg_wdata;
      // Compare a delivered answer with the oldest one outstanding.
      if (m_tvalid && m_tready) begin
        if (answers_due.size() == 0) begin
          $error("answer %h delivered with no request outstanding", m_tdata);
          errors++;
        end else begin
          if (m_tdata !== answers_due[0]) begin
            $error("answer mismatch: expected %h, actual %h", answers_due[0], m_tdata);
            errors++;
          end
          void'(answers_due.pop_front());
        end
      end
      if (s_tvalid && s_tready) answers_due.push_back(serve_request(s_tdata[2:0], s_tdata[34:3]));
    end
    due_count = answers_due.size();
  end

endmodule

// ===== verif/processor_unit_allocator_test.sv =====
`timescale 1ns / 1ps
module processor_unit_allocator_test;
  import pua_pkg::*;

  // Function codes the block leaves unused.
  localparam logic [2:0] FN_SPARE6 = 3'd6;
  localparam logic [2:0] FN_SPARE7 = 3'd7;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 240;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wen = 1'b0;
  logic [2:0]  cfg_wdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  int          fail_count;
  int          pending;
  int          cycles = 0;
  int          send_calm = 0;

  processor_unit_allocator dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  processor_unit_allocator_check check (
    .clk        (clk),
    .rst        (rst),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Hard stop if the run hangs.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Wait before the next handshake: mostly a random draw, with calm stretches of none.
  function automatic int draw_wait(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) begin
      calm_left = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 12);
  endfunction

  // Unit index argument: mostly near the valid range, sometimes any value.
  function automatic logic [31:0] unit_arg();
    if ($urandom_range(0, 4) == 0) return $urandom();
    return $urandom_range(0, 4);
  endfunction

  // Present one request and hold it until the block takes it.
  task automatic send_request(input logic [2:0] fn, input logic [31:0] arg);
    int gap;
    gap = draw_wait(send_calm);
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tdata = {5'd0, arg, fn};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Let every answer come back, then write the mini-BIOS mask.
  task automatic set_mask(input logic [2:0] value);
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_wdata = value;
    cfg_wen = 1'b1;
    @(negedge clk);
    cfg_wen = 1'b0;
  endtask

  // Answer side: random back-pressure between handshakes.
  initial begin : answer_sink
    int stall;
    int calm;
    calm = 0;
    while (rst) @(negedge clk);
    forever begin
      stall = draw_wait(calm);
      if (stall > 0) begin
        @(negedge clk);
        m_tready = 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      m_tready = 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  initial begin : stimulus
    int r;
    logic [2:0]  fn;
    logic [31:0] arg;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed requests with no mini-BIOS units.
    set_mask(3'd0);
    send_request(FN_STATUS, 32'd0);
    send_request(FN_STATUS, 32'd3);
    send_request(FN_STATUS, 32'd4);
    send_request(FN_STATUS, 32'hFFFF_FFFF);
    send_request(FN_COUNT, 32'd1);
    send_request(FN_COUNT, 32'd0);
    send_request(FN_ALLOC, 32'd7);
    send_request(FN_ALLOC, 32'd0);
    send_request(FN_ALLOC, 32'hFFFF_FFF0);
    // Every allocatable unit is taken now, so this one finds nothing.
    send_request(FN_ALLOC, 32'd0);
    send_request(FN_FREE, 32'd1);
    send_request(FN_FREE, 32'd1);
    send_request(FN_FREE, 32'd3);
    send_request(FN_SPEC, 32'd1);
    send_request(FN_SPEC, 32'd1);
    send_request(FN_SPEC, 32'd3);
    send_request(FN_SPARE6, 32'd5);
    send_request(FN_SPARE7, 32'hFFFF_FFFF);
    send_request(FN_RESET, 32'd2);
    send_request(FN_RESET, 32'hFFFF_FFFF);

    // Directed requests with units 0..2 running the mini BIOS.
    set_mask(3'd7);
    send_request(FN_RESET, 32'd5);
    send_request(FN_ALLOC, 32'd8);
    send_request(FN_ALLOC, 32'd9);
    send_request(FN_STATUS, 32'd2);
    send_request(FN_COUNT, 32'd7);

    // Random phases, each under its own mask, both extremes included.
    for (int p = 0; p < PHASES; p++) begin
      if (p == 0) set_mask(3'd0);
      else if (p == 1) set_mask(3'd7);
      else set_mask(3'($urandom_range(0, 7)));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          fn = FN_RESET;
          arg = unit_arg();
        end else if (r < 38) begin
          fn = FN_ALLOC;
          arg = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 15);
        end else if (r < 53) begin
          fn = FN_SPEC;
          arg = unit_arg();
        end else if (r < 73) begin
          fn = FN_FREE;
          arg = unit_arg();
        end else if (r < 85) begin
          fn = FN_STATUS;
          arg = unit_arg();
        end else if (r < 95) begin
          fn = FN_COUNT;
          arg = ($urandom_range(0, 2) == 0) ? $urandom() : $urandom_range(0, 2);
        end else begin
          fn = ($urandom_range(0, 1) == 0) ? FN_SPARE6 : FN_SPARE7;
          arg = $urandom();
        end
        send_request(fn, arg);
      end
    end

    // Drain the outstanding answers and give the verdict.
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/pua_pkg.sv
rtl/core/pua_eval.sv
rtl/core/processor_unit_allocator.sv
rtl/core/pua_checker.sv
verif/processor_unit_allocator_check.sv
verif/processor_unit_allocator_test.sv
